FILE: hdl/julian_day_to_calendar_date_defines.svh
// Assertion macros used by the top level of the day-number-to-date converter.
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define JDCD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jdcd: assertion failed");
// Check cons in the cycle after ante.
`define JDCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jdcd: assertion failed");
`else
`define JDCD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define JDCD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/jdcd_pkg.sv
// Shared constants, types and the month table of the day-number-to-date converter.
`default_nettype none

package jdcd_pkg;

   // Calendar anchors, in day numbers and day counts
   localparam int unsigned BC_DAYS           = 1721424; // 1 Jan 4713 BC up to 1 Jan 1 AD
   localparam int unsigned GREG_START        = 2299161; // 15 Oct 1582
   localparam int unsigned GREG_1583         = 2299239; // 1 Jan 1583
   localparam int unsigned DAYS_1201_TO_1583 = 139522;
   localparam int unsigned CYCLE4            = 1461;
   localparam int unsigned CYCLE100          = 36524;
   localparam int unsigned CYCLE400          = 146097;
   localparam int unsigned DAYS_YEAR         = 365;
   localparam int unsigned DAYS_LEAP         = 366;

   localparam int unsigned YEAR_BC_TOP    = 4713;
   localparam int unsigned YEAR_GAP       = 1582;
   localparam int unsigned YEAR_GREG_BASE = 1201;
   localparam int unsigned GAP_DOY        = 287;  // 15 Oct is day 287 of a common year

   // Field widths
   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 24;
   localparam int DOY_W  = 9;

   // Offset width for the pre-Gregorian range, and widths of the split values
   localparam int XW      = 21;
   localparam int R4_W    = $clog2(CYCLE4);
   localparam int R100_W  = 16;
   localparam int R400_W  = $clog2(CYCLE400);
   localparam int QJ_W    = XW + 1 - R4_W;
   localparam int N4_MAX  = CYCLE100 / CYCLE4;
   localparam int N4_W    = 5;
   localparam int N100_MAX = 3;

   // Calendar range codes
   typedef logic [1:0] era_type;
   localparam era_type ERA_BC   = 2'd0;
   localparam era_type ERA_JUL  = 2'd1;
   localparam era_type ERA_GAP  = 2'd2;
   localparam era_type ERA_GREG = 2'd3;

   // Year-level result ahead of the month split
   typedef struct packed {
      logic [DOY_W-1:0]  doy;
      logic              leap;
      logic [YEAR_W-1:0] year;
      logic              bc;
   } date_type;

   // First day of month idx (0-based), day of year; idx 12 gives the year length
   function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                    input logic [MON_W-1:0] idx);
      logic [DOY_W-1:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         4'd12:   base = 9'd365;
         default: base = 9'd0;
      endcase
      return base + DOY_W'(leap && (idx >= 4'd2));
   endfunction

endpackage

`default_nettype wire

FILE: hdl/jdcd_cdiv.sv
// Three-stage divider by a constant: reciprocal multiply, back-multiply, correction.
`default_nettype none

module jdcd_cdiv #(
   parameter int IN_W    = 32,
   parameter int DIVISOR = 146097
) (
   input  wire logic                              clock,
   input  wire logic [IN_W-1:0]                   in_val,
   output logic [IN_W-$clog2(DIVISOR):0]          quo,
   output logic [$clog2(DIVISOR)-1:0]             rem
);

   localparam int SH = (IN_W > 32) ? IN_W - 32 : 0;
   localparam int TW = IN_W - SH;
   localparam int CW = $clog2(DIVISOR);
   localparam int QW = IN_W + 1 - CW;
   localparam int MW = 33 + SH - CW;
   localparam int PW = TW + MW;
   localparam longint unsigned RECIP = (64'd1 << (32 + SH)) / longint'(DIVISOR);
   localparam logic [MW-1:0]   RECIP_M = MW'(RECIP);
   localparam logic [CW-1:0]   DIV_C   = CW'(DIVISOR);
   localparam logic [CW+1:0]   DIV_C1  = (CW+2)'(DIVISOR);
   localparam logic [CW+1:0]   DIV_C2  = (CW+2)'(2 * DIVISOR);

   logic [PW-1:0]   prod_ff;
   logic [IN_W-1:0] x_a_ff;
   logic [QW-1:0]   q_b_ff;
   logic [IN_W:0]   qc_b_ff;
   logic [IN_W-1:0] x_b_ff;
   logic [QW-1:0]   q_est;
   logic [IN_W:0]   diff;
   logic [CW+1:0]   r0;
   logic [CW+1:0]   r1;
   logic [CW+1:0]   r2;
   logic [QW-1:0]   quo_in;
   logic [CW-1:0]   rem_in;
   logic [QW-1:0]   quo_ff;
   logic [CW-1:0]   rem_ff;

   // Estimate quotient from the top bits; it runs at most two low
   assign q_est = prod_ff[PW-1:32];

   // Remove the estimate and fix up by up to two divisors
   always_comb begin
      diff = {1'b0, x_b_ff} - qc_b_ff;
      r0   = diff[CW+1:0];
      r1   = r0 - DIV_C1;
      r2   = r0 - DIV_C2;
      priority if (r0 >= DIV_C2) begin
         quo_in = q_b_ff + QW'(2);
         rem_in = r2[CW-1:0];
      end else if (r0 >= DIV_C1) begin
         quo_in = q_b_ff + QW'(1);
         rem_in = r1[CW-1:0];
      end else begin
         quo_in = q_b_ff;
         rem_in = r0[CW-1:0];
      end
   end

   // Advance the three stages
   always_ff @(posedge clock) begin
      prod_ff <= PW'(in_val[IN_W-1:SH]) * PW'(RECIP_M);
      x_a_ff  <= in_val;
      q_b_ff  <= q_est;
      qc_b_ff <= (IN_W+1)'(q_est) * (IN_W+1)'(DIV_C);
      x_b_ff  <= x_a_ff;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign quo = quo_ff;
   assign rem = rem_ff;

endmodule

`default_nettype wire

FILE: hdl/jdcd_julian.sv
// Year and day of year for the BC and Julian AD ranges from a four-year split.
`default_nettype none

module jdcd_julian
   import jdcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [QJ_W-1:0]   k,
   input  wire logic [R4_W-1:0]   r,
   input  wire logic              bc,
   output date_type               date
);

   localparam logic [R4_W-1:0] L1 = R4_W'(DAYS_LEAP);
   localparam logic [R4_W-1:0] L2 = R4_W'(DAYS_LEAP + DAYS_YEAR);
   localparam logic [R4_W-1:0] L3 = R4_W'(DAYS_LEAP + 2 * DAYS_YEAR);
   localparam logic [R4_W-1:0] J1 = R4_W'(DAYS_YEAR);
   localparam logic [R4_W-1:0] J2 = R4_W'(2 * DAYS_YEAR);
   localparam logic [R4_W-1:0] J3 = R4_W'(3 * DAYS_YEAR);

   logic [1:0]        ob;
   logic [1:0]        oj;
   logic [R4_W-1:0]   sub_b;
   logic [R4_W-1:0]   sub_j;
   logic [YEAR_W-1:0] k4;
   date_type          date_in;
   date_type          date_ff;

   always_comb begin
      // Each BC four-year group opens with the leap year
      ob = 2'(r >= L1) + 2'(r >= L2) + 2'(r >= L3);
      unique case (ob)
         2'd0:    sub_b = '0;
         2'd1:    sub_b = L1;
         2'd2:    sub_b = L2;
         default: sub_b = L3;
      endcase
      // Each Julian AD four-year group closes with the leap year
      oj    = 2'(r >= J1) + 2'(r >= J2) + 2'(r >= J3);
      sub_j = R4_W'(oj) * J1;
      k4    = YEAR_W'(k) << 2;
      if (bc) begin
         date_in.doy  = DOY_W'(r - sub_b);
         date_in.leap = (ob == 2'd0);
         date_in.year = YEAR_W'(YEAR_BC_TOP) - k4 - YEAR_W'(ob);
         date_in.bc   = 1'b1;
      end else begin
         date_in.doy  = DOY_W'(r - sub_j);
         date_in.leap = (oj == 2'd3);
         date_in.year = k4 + YEAR_W'(oj) + YEAR_W'(1);
         date_in.bc   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      date_ff <= date_in;
   end

   assign date = date_ff;

endmodule

`default_nettype wire

FILE: hdl/jdcd_greg.sv
// Three-stage Gregorian split of a 400-year remainder into century, quad and year.
`default_nettype none

module jdcd_greg
   import jdcd_pkg::*;
#(
   parameter int Q_W = 15
) (
   input  wire logic                clock,
   input  wire logic [Q_W-1:0]      n400,
   input  wire logic [R400_W-1:0]   r400,
   output date_type                 date
);

   localparam logic [R400_W-1:0] C1 = R400_W'(CYCLE100);
   localparam logic [R400_W-1:0] C2 = R400_W'(2 * CYCLE100);
   localparam logic [R400_W-1:0] C3 = R400_W'(3 * CYCLE100);
   localparam logic [R4_W-1:0]   Y1 = R4_W'(DAYS_YEAR);
   localparam logic [R4_W-1:0]   Y2 = R4_W'(2 * DAYS_YEAR);
   localparam logic [R4_W-1:0]   Y3 = R4_W'(3 * DAYS_YEAR);

   logic [1:0]          n100_in;
   logic [R400_W-1:0]   d100;
   logic [R100_W-1:0]   r100_in;
   logic [YEAR_W-1:0]   ybase_in;
   logic [1:0]          n100_ff;
   logic [R100_W-1:0]   r100_ff;
   logic [YEAR_W-1:0]   ybase_ff;

   logic [N4_W-1:0]     n4;
   logic [R100_W-1:0]   d4;
   logic [R4_W-1:0]     r4_in;
   logic [YEAR_W-1:0]   year6_in;
   logic                leapok_in;
   logic [R4_W-1:0]     r4_ff;
   logic [YEAR_W-1:0]   year6_ff;
   logic                leapok_ff;

   logic [1:0]          n1;
   logic [R4_W-1:0]     d1;
   date_type            date_in;
   date_type            date_ff;

   // Split off centuries; the last century of a cycle keeps the extra day
   always_comb begin
      n100_in  = 2'(r400 >= C1) + 2'(r400 >= C2) + 2'(r400 >= C3);
      d100     = r400 - R400_W'(n100_in) * C1;
      r100_in  = d100[R100_W-1:0];
      ybase_in = YEAR_W'(YEAR_GREG_BASE) + YEAR_W'(n400) * YEAR_W'(400)
               + YEAR_W'(n100_in) * YEAR_W'(100);
   end

   // Split off four-year groups with a compare ladder
   always_comb begin
      n4 = '0;
      for (int j = 1; j <= N4_MAX; j++) begin
         if (r100_ff >= R100_W'(j * CYCLE4)) n4 = N4_W'(j);
      end
      d4        = r100_ff - R100_W'(n4) * R100_W'(CYCLE4);
      r4_in     = d4[R4_W-1:0];
      year6_in  = ybase_ff + YEAR_W'({n4, 2'b00});
      leapok_in = (n4 != N4_W'(N4_MAX)) || (n100_ff == 2'(N100_MAX));
   end

   // Split off single years; the fourth one of a group is the leap year
   always_comb begin
      n1           = 2'(r4_ff >= Y1) + 2'(r4_ff >= Y2) + 2'(r4_ff >= Y3);
      d1           = r4_ff - R4_W'(n1) * Y1;
      date_in.doy  = DOY_W'(d1);
      date_in.leap = (n1 == 2'd3) && leapok_ff;
      date_in.year = year6_ff + YEAR_W'(n1);
      date_in.bc   = 1'b0;
   end

   always_ff @(posedge clock) begin
      n100_ff   <= n100_in;
      r100_ff   <= r100_in;
      ybase_ff  <= ybase_in;
      r4_ff     <= r4_in;
      year6_ff  <= year6_in;
      leapok_ff <= leapok_in;
      date_ff   <= date_in;
   end

   assign date = date_ff;

endmodule

`default_nettype wire

FILE: hdl/jdcd_month.sv
// Month split of a day of year and the result register with its strobe.
`default_nettype none

module jdcd_month
   import jdcd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid,
   input  wire date_type           date,
   output logic                    strobe,
   output logic [DAY_W-1:0]        day_of_month,
   output logic [MON_W-1:0]        month,
   output logic [YEAR_W-1:0]       year_value,
   output logic                    before_era
);

   logic [MON_W-1:0]  m;
   logic [DOY_W-1:0]  day_w;
   logic              strobe_ff;
   logic [DAY_W-1:0]  day_ff;
   logic [MON_W-1:0]  month_ff;
   logic [YEAR_W-1:0] year_ff;
   logic              bc_ff;

   // Find the month by comparing against every month start
   always_comb begin
      m = '0;
      for (int j = 1; j <= 11; j++) begin
         if (date.doy >= month_start(date.leap, MON_W'(j))) m = MON_W'(j);
      end
      day_w = date.doy - month_start(date.leap, m) + DOY_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_w[DAY_W-1:0];
      month_ff <= m + MON_W'(1);
      year_ff  <= date.year;
      bc_ff    <= date.bc;
   end

   assign strobe       = strobe_ff;
   assign day_of_month = day_ff;
   assign month        = month_ff;
   assign year_value   = year_ff;
   assign before_era   = bc_ff;

endmodule

`default_nettype wire

FILE: hdl/julian_day_to_calendar_date.sv
// Top level of the day-number-to-calendar-date converter pipeline.
//
// Usage:
//   Drive a day number (0 = 1 January 4713 BC) on req_day_number and raise
//   start; the word is taken at a rising edge where start is high and busy is
//   low. busy never rises, so a new word may be given in every cycle.
//   Each result sits on the rsp_ ports for one cycle with rsp_strobe high;
//   results come out in order.
//   Throughput is one word per cycle; the pipeline runs through the
//   input register, the range classifier, the three stages of the constant
//   dividers (reciprocal multiply, back-multiply, correction), the three-step
//   Gregorian century/quad/year split and the month split.
//   The receiver cannot stall: results must be taken when strobed.
//   Dates from 5 to 14 October 1582 are never produced; the year wraps at
//   24 bits when DAY_WIDTH is above 32.
//   Reset (synchronous, active high) drops every word in flight; no strobe
//   follows a word taken before or during reset.
`default_nettype none
`include "julian_day_to_calendar_date_defines.svh"

module julian_day_to_calendar_date
   import jdcd_pkg::*;
#(
   parameter int DAY_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DAY_WIDTH-1:0]  req_day_number,
   output logic                       rsp_strobe,
   output logic [DAY_W-1:0]           rsp_day_of_month,
   output logic [MON_W-1:0]           rsp_month,
   output logic [YEAR_W-1:0]          rsp_year_value,
   output logic                       rsp_before_era
);

   localparam int QG_W = DAY_WIDTH + 1 - R400_W;
   localparam logic [DAY_WIDTH-1:0] G_OFFSET =
      DAY_WIDTH'(GREG_1583 - DAYS_1201_TO_1583);

   logic                  req_accept;
   logic [7:0]            vld_ff;
   logic [DAY_WIDTH-1:0]  d_ff;

   era_type               era_in;
   logic [XW-1:0]         x_in;
   logic [DAY_WIDTH-1:0]  g_in;
   logic [DOY_W-1:0]      gdoy_in;
   era_type               era_ff [1:7];
   logic [DOY_W-1:0]      gdoy_ff [1:7];
   logic [XW-1:0]         x_ff;
   logic [DAY_WIDTH-1:0]  g_ff;

   logic [QJ_W-1:0]       j_quo;
   logic [R4_W-1:0]       j_rem;
   logic [QG_W-1:0]       g_quo;
   logic [R400_W-1:0]     g_rem;

   date_type              jul_date;
   date_type              jul6_ff;
   date_type              jul7_ff;
   date_type              greg_date;
   date_type              merged;

   assign busy       = 1'b0;
   assign req_accept = start && !busy;

   // Advance the valid bits; reset drops every word in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[6:0], req_accept};
      end
   end

   // Classify the day number and form the per-range offsets
   always_comb begin
      priority if (d_ff < DAY_WIDTH'(BC_DAYS)) begin
         era_in = ERA_BC;
      end else if (d_ff < DAY_WIDTH'(GREG_START)) begin
         era_in = ERA_JUL;
      end else if (d_ff < DAY_WIDTH'(GREG_1583)) begin
         era_in = ERA_GAP;
      end else begin
         era_in = ERA_GREG;
      end
      x_in    = (era_in == ERA_BC) ? d_ff[XW-1:0] : d_ff[XW-1:0] - XW'(BC_DAYS);
      g_in    = d_ff - G_OFFSET;
      gdoy_in = d_ff[DOY_W-1:0] - DOY_W'(GREG_START) + DOY_W'(GAP_DOY);
   end

   // Hold the input word, the offsets and the range code down the pipe
   always_ff @(posedge clock) begin
      if (req_accept) d_ff <= req_day_number;
      x_ff       <= x_in;
      g_ff       <= g_in;
      era_ff[1]  <= era_in;
      gdoy_ff[1] <= gdoy_in;
      for (int i = 2; i <= 7; i++) begin
         era_ff[i]  <= era_ff[i-1];
         gdoy_ff[i] <= gdoy_ff[i-1];
      end
      jul6_ff <= jul_date;
      jul7_ff <= jul6_ff;
   end

   jdcd_cdiv #(
      .IN_W    (XW),
      .DIVISOR (CYCLE4)
   ) u_div_jul (
      .clock  (clock),
      .in_val (x_ff),
      .quo    (j_quo),
      .rem    (j_rem)
   );

   jdcd_cdiv #(
      .IN_W    (DAY_WIDTH),
      .DIVISOR (CYCLE400)
   ) u_div_greg (
      .clock  (clock),
      .in_val (g_ff),
      .quo    (g_quo),
      .rem    (g_rem)
   );

   jdcd_julian u_julian (
      .clock (clock),
      .k     (j_quo),
      .r     (j_rem),
      .bc    (era_ff[4] == ERA_BC),
      .date  (jul_date)
   );

   jdcd_greg #(
      .Q_W (QG_W)
   ) u_greg (
      .clock (clock),
      .n400  (g_quo),
      .r400  (g_rem),
      .date  (greg_date)
   );

   // Pick the year-level result of the range the word fell in
   always_comb begin
      unique case (era_ff[7])
         ERA_BC, ERA_JUL: begin
            merged = jul7_ff;
         end
         ERA_GAP: begin
            merged.doy  = gdoy_ff[7];
            merged.leap = 1'b0;
            merged.year = YEAR_W'(YEAR_GAP);
            merged.bc   = 1'b0;
         end
         ERA_GREG: begin
            merged = greg_date;
         end
      endcase
   end

   jdcd_month u_month (
      .clock        (clock),
      .reset        (reset),
      .valid        (vld_ff[7]),
      .date         (merged),
      .strobe       (rsp_strobe),
      .day_of_month (rsp_day_of_month),
      .month        (rsp_month),
      .year_value   (rsp_year_value),
      .before_era   (rsp_before_era)
   );

   `JDCD_ASSERT_NOW(a_latency, clock, reset, req_accept, ##9 rsp_strobe)
   `JDCD_ASSERT_NOW(a_no_ghost, clock, reset, rsp_strobe, $past(req_accept, 9))
   `JDCD_ASSERT_NOW(a_div_rem, clock, reset, vld_ff[4],
      (g_rem < R400_W'(CYCLE400)) && (j_rem < R4_W'(CYCLE4)))
   `JDCD_ASSERT_NOW(a_doy_range, clock, reset, vld_ff[7],
      (merged.doy < DOY_W'(DAYS_LEAP)) && (merged.leap || (merged.doy < DOY_W'(DAYS_YEAR))))
   `JDCD_ASSERT_NOW(a_bc_year, clock, reset, rsp_strobe && rsp_before_era,
      (rsp_year_value != '0) && (rsp_year_value <= YEAR_W'(YEAR_BC_TOP)))

endmodule

`default_nettype wire
